@@ src/ptss_pkg.sv @@
// Shared types and constants for the prime test, prime sum and two-prime split block.
package ptss_pkg;

    localparam int SumBits  = 40;
    localparam int PartBits = 16;
    localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

    typedef enum logic [1:0] {
        OP_PRIME = 2'd0,
        OP_SUM   = 2'd1,
        OP_SPLIT = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHK  = 6'b000010,
        S_TEST = 6'b000100,
        S_DIV  = 6'b001000,
        S_RET  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage

@@ src/prime_test_sum_and_split.sv @@
// Top level: trial-division prime test, sum of first primes and two-prime split.
//
//  channel  signals                        direction  payload
//  in       i_in_valid / o_in_ready        input      i_opcode, i_operand
//  out      o_out_valid / i_out_ready      output     o_is_prime, o_prime_sum,
//                                                     o_first_part, o_second_part, o_no_pair
//
// One transaction at a time; o_in_ready is low from acceptance until the result is taken.
// Each trial division is one test step in S_TEST plus a bit-serial remainder in S_DIV;
// up to about sqrt(v) / 2 odd divisors are tried per tested value v. Sums and splits chain tests.
// Reset is synchronous, active low, and needs no clearing pass.
// A stalled output holds its result and blocks new input.
module prime_test_sum_and_split
    import ptss_pkg::*;
#(
    parameter int OPERAND_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_opcode,
    input  logic [OPERAND_BITS-1:0] i_operand,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_is_prime,
    output logic [SumBits-1:0]      o_prime_sum,
    output logic [PartBits-1:0]     o_first_part,
    output logic [PartBits-1:0]     o_second_part,
    output logic                    o_no_pair
);

    localparam int CandBits = (OPERAND_BITS > 24) ? OPERAND_BITS : 24;
    localparam int DivBits  = (CandBits + 1) / 2 + 1;
    localparam int SqBits   = CandBits + 1;

    t_state                  r_state, n_state;
    t_opcode                 r_op, n_op;
    logic [OPERAND_BITS-1:0] r_v, n_v;
    logic [OPERAND_BITS-1:0] r_a, n_a;
    logic [OPERAND_BITS-1:0] r_count, n_count;
    logic                    r_phase_b, n_phase_b;
    logic [CandBits-1:0]     r_cand, n_cand;
    logic [DivBits-1:0]      r_d, n_d;
    logic [SqBits-1:0]       r_sq, n_sq;
    logic                    r_isp, n_isp;
    logic [SumBits-1:0]      r_sum, n_sum;
    logic                    r_is_prime, n_is_prime;
    logic [PartBits-1:0]     r_first, n_first;
    logic [PartBits-1:0]     r_second, n_second;
    logic                    r_no_pair, n_no_pair;

    logic                    w_rem_start;
    logic                    w_rem_done;
    logic [DivBits-1:0]      w_rem;
    logic [SumBits:0]        w_sum_ext;
    logic [OPERAND_BITS-1:0] w_count_inc;
    logic [OPERAND_BITS-1:0] w_a_inc;

    ptss_rem #(
        .DIVIDEND_BITS (CandBits),
        .DIVISOR_BITS  (DivBits)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_cand),
        .i_divisor  (r_d),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    assign w_sum_ext   = {1'b0, r_sum} + (SumBits + 1)'(r_cand);
    assign w_count_inc = r_count + OPERAND_BITS'(1);
    assign w_a_inc     = r_a + OPERAND_BITS'(1);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_v        = r_v;
        n_a        = r_a;
        n_count    = r_count;
        n_phase_b  = r_phase_b;
        n_cand     = r_cand;
        n_d        = r_d;
        n_sq       = r_sq;
        n_isp      = r_isp;
        n_sum      = r_sum;
        n_is_prime = r_is_prime;
        n_first    = r_first;
        n_second   = r_second;
        n_no_pair  = r_no_pair;
        w_rem_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = t_opcode'(i_opcode);
                    n_v        = i_operand;
                    n_is_prime = 1'b0;
                    n_sum      = '0;
                    n_first    = '0;
                    n_second   = '0;
                    n_no_pair  = 1'b0;
                    n_count    = '0;
                    n_phase_b  = 1'b0;
                    n_a        = OPERAND_BITS'(2);
                    unique case (t_opcode'(i_opcode))
                        OP_PRIME: begin
                            n_cand  = CandBits'(i_operand);
                            n_state = S_CHK;
                        end
                        OP_SUM: begin
                            n_cand  = CandBits'(2);
                            n_state = (i_operand == '0) ? S_OUT : S_CHK;
                        end
                        OP_SPLIT: begin
                            if (i_operand < OPERAND_BITS'(4)) begin
                                n_no_pair = 1'b1;
                                n_state   = S_OUT;
                            end else if (i_operand[0]) begin
                                n_cand  = CandBits'(i_operand - OPERAND_BITS'(2));
                                n_state = S_CHK;
                            end else begin
                                n_cand  = CandBits'(2);
                                n_state = S_CHK;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_CHK: begin
                priority if (r_cand < CandBits'(2)) begin
                    n_isp   = 1'b0;
                    n_state = S_RET;
                end else if (r_cand < CandBits'(4)) begin
                    n_isp   = 1'b1;
                    n_state = S_RET;
                end else if (!r_cand[0]) begin
                    n_isp   = 1'b0;
                    n_state = S_RET;
                end else begin
                    n_d     = DivBits'(3);
                    n_sq    = SqBits'(9);
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (r_sq > {1'b0, r_cand}) begin
                    n_isp   = 1'b1;
                    n_state = S_RET;
                end else begin
                    w_rem_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rem_done) begin
                    if (w_rem == '0) begin
                        n_isp   = 1'b0;
                        n_state = S_RET;
                    end else begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        n_d     = r_d + DivBits'(2);
                        n_sq    = r_sq + SqBits'({r_d, 2'b00}) + SqBits'(4);
                        n_state = S_TEST;
                    end
                end
            end
            S_RET: begin
                unique case (r_op)
                    OP_PRIME: begin
                        n_is_prime = r_isp;
                        n_state    = S_OUT;
                    end
                    OP_SUM: begin
                        if (r_isp) begin
                            n_count = w_count_inc;
                            if (w_sum_ext[SumBits]) begin
                                n_sum   = SumMax;
                                n_state = S_OUT;
                            end else begin
                                n_sum   = w_sum_ext[SumBits-1:0];
                                n_cand  = r_cand + CandBits'(1);
                                n_state = (w_count_inc == r_v) ? S_OUT : S_CHK;
                            end
                        end else begin
                            n_cand  = r_cand + CandBits'(1);
                            n_state = S_CHK;
                        end
                    end
                    OP_SPLIT: begin
                        if (r_v[0]) begin
                            if (r_isp) begin
                                n_first  = PartBits'(2);
                                n_second = PartBits'(r_cand);
                            end else begin
                                n_no_pair = 1'b1;
                            end
                            n_state = S_OUT;
                        end else if (r_isp && !r_phase_b) begin
                            n_phase_b = 1'b1;
                            n_cand    = CandBits'(r_v - r_a);
                            n_state   = S_CHK;
                        end else if (r_isp) begin
                            n_first  = PartBits'(r_a);
                            n_second = PartBits'(r_cand);
                            n_state  = S_OUT;
                        end else if (w_a_inc > (r_v >> 1)) begin
                            n_no_pair = 1'b1;
                            n_state   = S_OUT;
                        end else begin
                            n_a       = w_a_inc;
                            n_phase_b = 1'b0;
                            n_cand    = CandBits'(w_a_inc);
                            n_state   = S_CHK;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_v        <= n_v;
        r_a        <= n_a;
        r_count    <= n_count;
        r_phase_b  <= n_phase_b;
        r_cand     <= n_cand;
        r_d        <= n_d;
        r_sq       <= n_sq;
        r_isp      <= n_isp;
        r_sum      <= n_sum;
        r_is_prime <= n_is_prime;
        r_first    <= n_first;
        r_second   <= n_second;
        r_no_pair  <= n_no_pair;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_is_prime    = r_is_prime;
    assign o_prime_sum   = r_sum;
    assign o_first_part  = r_first;
    assign o_second_part = r_second;
    assign o_no_pair     = r_no_pair;

endmodule

@@ src/ptss_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ptss_rem #(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 13
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]  i_divisor,
    output logic                     o_done,
    output logic [DIVISOR_BITS-1:0]  o_rem
);

    localparam int CntBits = $clog2(DIVIDEND_BITS + 1);

    logic                     r_busy;
    logic                     r_done;
    logic [CntBits-1:0]       r_cnt;
    logic [DIVIDEND_BITS-1:0] r_shift;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS:0]    w_shifted;
    logic [DIVISOR_BITS:0]    w_diff;

    assign w_shifted = {r_rem, r_shift[DIVIDEND_BITS-1]};
    assign w_diff    = w_shifted - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntBits'(DIVIDEND_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CntBits'(1);
                if (r_cnt == CntBits'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[DIVIDEND_BITS-2:0], 1'b0};
            if (!w_diff[DIVISOR_BITS]) begin
                r_rem <= w_diff[DIVISOR_BITS-1:0];
            end else begin
                r_rem <= w_shifted[DIVISOR_BITS-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
